FILE: rtl/core/prr_pkg.sv
// Types, codes and constants shared by the packet request receiver.
package prr_pkg;

   localparam int STATE_AREA_BYTES_DEF = 6;

   localparam logic [7:0] REQ_MARK   = 8'd85;
   localparam logic [7:0] REPLY_MARK = 8'd170;

   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_BYTE    = 2'd1;
   localparam logic [1:0] OP_TIMEOUT = 2'd2;

   localparam logic [1:0] KIND_TX      = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_DONE    = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_OFFLINE   = 3'd1;
   localparam logic [2:0] ST_BAD_HDR   = 3'd2;
   localparam logic [2:0] ST_TRUNCATED = 3'd3;
   localparam logic [2:0] ST_CORRUPT   = 3'd4;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] command;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [7:0] index;
      logic       to_state_area;
      logic [2:0] status;
      logic       acknowledged;
      logic       last;
   } rsp_type;

   // Result group of one item: nothing, one beat, or the three transmit beats.
   typedef struct packed {
      logic       valid;
      logic       triple;
      logic [7:0] tx_id;
      rsp_type    rsp;
   } res_type;

endpackage

FILE: rtl/core/prr_parser.sv
// Reply parser: exchange state and the results of one item.
module prr_parser
   import prr_pkg::*;
#(
   parameter int STATE_AREA_BYTES = STATE_AREA_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  req_type    item,
   input  logic [7:0] state_command,
   output res_type    res
);

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_HEADER  = 3'd1,
      PH_ID      = 3'd2,
      PH_LEN     = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CHECK   = 3'd5
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [2:0] link_status_ff, link_status_in;
   logic [7:0] last_id_ff, last_id_in;
   logic [7:0] pending_ff, pending_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] reply_id_ff, reply_id_in;
   logic       is_state_cmd;

   assign is_state_cmd = (pending_ff == state_command);

   always_comb begin
      phase_in       = phase_ff;
      link_status_in = link_status_ff;
      last_id_in     = last_id_ff;
      pending_in     = pending_ff;
      sum_in         = sum_ff;
      length_in      = length_ff;
      count_in       = count_ff;
      reply_id_in    = reply_id_ff;
      res            = '0;
      unique case (item.op)
         OP_START: begin
            res.valid    = 1'b1;
            res.triple   = 1'b1;
            res.tx_id    = last_id_ff;
            res.rsp.kind = KIND_TX;
            res.rsp.data = item.command;
            pending_in   = item.command;
            phase_in     = PH_HEADER;
         end
         OP_TIMEOUT: begin
            if (phase_ff != PH_IDLE) begin
               res.valid      = 1'b1;
               res.rsp.kind   = KIND_DONE;
               res.rsp.status = link_status_ff;
               res.rsp.last   = 1'b1;
               phase_in       = PH_IDLE;
            end
         end
         OP_BYTE: begin
            unique case (phase_ff)
               PH_IDLE: begin
               end
               PH_HEADER: begin
                  if (item.rx_byte != REPLY_MARK) begin
                     link_status_in = ST_BAD_HDR;
                     phase_in       = PH_IDLE;
                     res.valid      = 1'b1;
                     res.rsp.kind   = KIND_DONE;
                     res.rsp.status = ST_BAD_HDR;
                     res.rsp.last   = 1'b1;
                  end else begin
                     link_status_in = ST_TRUNCATED;
                     phase_in       = PH_ID;
                  end
               end
               PH_ID: begin
                  reply_id_in = item.rx_byte;
                  sum_in      = item.rx_byte;
                  phase_in    = PH_LEN;
               end
               PH_LEN: begin
                  length_in = item.rx_byte;
                  count_in  = '0;
                  phase_in  = (item.rx_byte != 8'd0) ? PH_PAYLOAD : PH_CHECK;
               end
               PH_PAYLOAD: begin
                  res.valid             = 1'b1;
                  res.rsp.kind          = KIND_PAYLOAD;
                  res.rsp.data          = item.rx_byte;
                  res.rsp.index         = count_ff;
                  res.rsp.to_state_area = is_state_cmd &&
                                          (count_ff < 8'(STATE_AREA_BYTES));
                  res.rsp.last          = 1'b1;
                  sum_in                = sum_ff + item.rx_byte;
                  count_in              = count_ff + 8'd1;
                  if (count_in == length_ff) begin
                     phase_in = PH_CHECK;
                  end
               end
               PH_CHECK: begin
                  phase_in     = PH_IDLE;
                  res.valid    = 1'b1;
                  res.rsp.kind = KIND_DONE;
                  res.rsp.last = 1'b1;
                  if (item.rx_byte != sum_ff) begin
                     link_status_in = ST_CORRUPT;
                     res.rsp.status = ST_CORRUPT;
                  end else begin
                     link_status_in = ST_OK;
                     res.rsp.status = ST_OK;
                     if (is_state_cmd) begin
                        res.rsp.acknowledged = 1'b1;
                     end else if (reply_id_ff != last_id_ff) begin
                        last_id_in           = reply_id_ff;
                        res.rsp.acknowledged = 1'b1;
                     end
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         link_status_ff <= ST_OFFLINE;
         last_id_ff     <= '0;
         pending_ff     <= '0;
         sum_ff         <= '0;
         length_ff      <= '0;
         count_ff       <= '0;
         reply_id_ff    <= '0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         link_status_ff <= link_status_in;
         last_id_ff     <= last_id_in;
         pending_ff     <= pending_in;
         sum_ff         <= sum_in;
         length_ff      <= length_in;
         count_ff       <= count_in;
         reply_id_ff    <= reply_id_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (count_ff != length_ff))
      else $error("payload count reached length while still in payload");

   a_idle_no_byte_result: assert property (@(posedge clock) disable iff (reset)
      (advance && phase_ff == PH_IDLE && item.op != OP_START) |-> !res.valid)
      else $error("result produced while idle");

   a_bad_header_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && res.valid && res.rsp.kind == KIND_DONE && res.rsp.status == ST_BAD_HDR)
      |=> (phase_ff == PH_IDLE && link_status_ff == ST_BAD_HDR))
      else $error("bad header did not end the exchange");
`endif

endmodule

FILE: rtl/core/packet_request_receiver_core.sv
// Top level of the packet request receiver: input register, parser, result register.
// An item's first result beat is registered as the item leaves the input register.
// Throughput: one item per cycle unless results stall; a start yields three result beats.
// An item waits in the input register until the last pending result beat is taken.
// Synchronous active-high reset: exchange idle, link offline, stored packet ID zero.
// The csr register resets to zero and is always ready.
module packet_request_receiver_core
   import prr_pkg::*;
#(
   parameter int STATE_AREA_BYTES = STATE_AREA_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   logic       in_valid_ff;
   req_type    in_item_ff;
   logic [7:0] state_cmd_ff;
   logic       rsp_valid_ff;
   res_type    res_ff;
   logic [1:0] seq_ff;
   res_type    res;
   logic       beat_last;
   logic       out_free;
   logic       advance;

   assign beat_last = res_ff.triple ? (seq_ff == 2'd2) : res_ff.rsp.last;
   assign out_free  = !rsp_valid_ff || (rsp_ready && beat_last);
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   prr_parser #(
      .STATE_AREA_BYTES(STATE_AREA_BYTES)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .item         (in_item_ff),
      .state_command(state_cmd_ff),
      .res          (res)
   );

   always_comb begin
      rsp_data = res_ff.rsp;
      if (res_ff.triple) begin
         rsp_data.last = (seq_ff == 2'd2);
         unique case (seq_ff)
            2'd0:    rsp_data.data = REQ_MARK;
            2'd1:    rsp_data.data = res_ff.rsp.data;
            default: rsp_data.data = res_ff.tx_id;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seq_ff       <= '0;
         state_cmd_ff <= '0;
      end else begin
         if (csr_valid) begin
            state_cmd_ff <= csr_data;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= res.valid;
            seq_ff       <= '0;
         end else if (rsp_valid_ff && rsp_ready) begin
            if (beat_last) begin
               rsp_valid_ff <= 1'b0;
            end else begin
               seq_ff <= seq_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         res_ff <= res;
      end
   end

`ifndef SYNTHESIS
   a_advance_free: assert property (@(posedge clock) disable iff (reset)
      advance |-> (!rsp_valid_ff || (rsp_ready && beat_last)))
      else $error("parser advanced while a result beat was pending");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (!in_valid_ff || advance))
      else $error("input register overwritten");

   a_seq_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (res_ff.triple || seq_ff == 2'd0) && seq_ff != 2'd3)
      else $error("transmit beat counter out of range");

   a_status_done_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind != KIND_DONE) |->
      (rsp_data.status == ST_OK && !rsp_data.acknowledged))
      else $error("status or acknowledge on a non-completion beat");
`endif

endmodule

FILE: verif/packet_request_receiver_checker.sv
`timescale 1ns / 1ps
// Link parser model and result scoreboard for the packet request receiver core.
module packet_request_receiver_checker
   import prr_pkg::*;
#(
   parameter int AREA_BYTES = STATE_AREA_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_data,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [7:0] csr_data,
   output int         fail_count,
   output int         owed_count,
   output int         beats_seen,
   output int         exchanges_closed,
   output int         acks_seen
);

   typedef enum logic [2:0] {
      PARSE_IDLE,
      PARSE_HEADER,
      PARSE_ID,
      PARSE_LEN,
      PARSE_PAYLOAD,
      PARSE_CHECK
   } parse_phase_type;

   parse_phase_type phase;
   logic [2:0]   link_status;
   logic [7:0]   last_id;
   logic [7:0]   pend_cmd;
   logic [7:0]   running_sum;
   logic [7:0]   pay_len;
   logic [7:0]   pay_count;
   logic [7:0]   reply_id;
   logic [7:0]   state_cmd;
   rsp_type      beats_owed[$];

   function automatic rsp_type beat(input logic [1:0] kind, input logic [7:0] data,
                                    input logic [7:0] idx, input logic area,
                                    input logic [2:0] status, input logic ack,
                                    input logic last);
      rsp_type r;
      r.kind          = kind;
      r.data          = data;
      r.index         = idx;
      r.to_state_area = area;
      r.status        = status;
      r.acknowledged  = ack;
      r.last          = last;
      return r;
   endfunction

   function automatic string beat_text(input rsp_type r);
      return $sformatf("kind=%0d data=0x%02h index=%0d area=%0b status=%0d ack=%0b last=%0b",
                       r.kind, r.data, r.index, r.to_state_area, r.status,
                       r.acknowledged, r.last);
   endfunction

   task automatic parse_link_item(input req_type item);
      logic area;
      logic ack;
      case (item.op)
         OP_START: begin
            beats_owed.push_back(beat(KIND_TX, REQ_MARK, 8'd0, 1'b0, ST_OK, 1'b0, 1'b0));
            beats_owed.push_back(beat(KIND_TX, item.command, 8'd0, 1'b0, ST_OK, 1'b0, 1'b0));
            beats_owed.push_back(beat(KIND_TX, last_id, 8'd0, 1'b0, ST_OK, 1'b0, 1'b1));
            pend_cmd = item.command;
            phase    = PARSE_HEADER;
         end
         OP_TIMEOUT: begin
            if (phase != PARSE_IDLE) begin
               beats_owed.push_back(beat(KIND_DONE, 8'd0, 8'd0, 1'b0, link_status, 1'b0, 1'b1));
               phase = PARSE_IDLE;
            end
         end
         OP_BYTE: begin
            case (phase)
               PARSE_HEADER: begin
                  if (item.rx_byte != REPLY_MARK) begin
                     link_status = ST_BAD_HDR;
                     phase       = PARSE_IDLE;
                     beats_owed.push_back(beat(KIND_DONE, 8'd0, 8'd0, 1'b0, ST_BAD_HDR,
                                               1'b0, 1'b1));
                  end else begin
                     link_status = ST_TRUNCATED;
                     phase       = PARSE_ID;
                  end
               end
               PARSE_ID: begin
                  reply_id    = item.rx_byte;
                  running_sum = item.rx_byte;
                  phase       = PARSE_LEN;
               end
               PARSE_LEN: begin
                  pay_len   = item.rx_byte;
                  pay_count = 8'd0;
                  phase     = (item.rx_byte != 8'd0) ? PARSE_PAYLOAD : PARSE_CHECK;
               end
               PARSE_PAYLOAD: begin
                  area = (pend_cmd == state_cmd) && (pay_count < AREA_BYTES);
                  beats_owed.push_back(beat(KIND_PAYLOAD, item.rx_byte, pay_count, area, ST_OK,
                                            1'b0, 1'b1));
                  running_sum = running_sum + item.rx_byte;
                  pay_count   = pay_count + 8'd1;
                  if (pay_count == pay_len)
                     phase = PARSE_CHECK;
               end
               PARSE_CHECK: begin
                  phase = PARSE_IDLE;
                  if (item.rx_byte != running_sum) begin
                     link_status = ST_CORRUPT;
                     beats_owed.push_back(beat(KIND_DONE, 8'd0, 8'd0, 1'b0, ST_CORRUPT,
                                               1'b0, 1'b1));
                  end else begin
                     link_status = ST_OK;
                     ack         = 1'b0;
                     if (pend_cmd == state_cmd) begin
                        ack = 1'b1;
                     end else if (reply_id != last_id) begin
                        last_id = reply_id;
                        ack     = 1'b1;
                     end
                     beats_owed.push_back(beat(KIND_DONE, 8'd0, 8'd0, 1'b0, ST_OK, ack, 1'b1));
                  end
               end
               default: phase = PARSE_IDLE;
            endcase
         end
         default: ;
      endcase
   endtask

   task automatic check_beat(input rsp_type got);
      rsp_type want;
      beats_seen++;
      if (beats_owed.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: unexpected beat %s", $time, beat_text(got));
      end else begin
         want = beats_owed.pop_front();
         if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: beat mismatch\n   expected %s\n   actual   %s",
                        $time, beat_text(want), beat_text(got));
         end
         if (want.kind == KIND_DONE) begin
            exchanges_closed++;
            if (want.acknowledged)
               acks_seen++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase       = PARSE_IDLE;
         link_status = ST_OFFLINE;
         last_id     = 8'd0;
         pend_cmd    = 8'd0;
         running_sum = 8'd0;
         pay_len     = 8'd0;
         pay_count   = 8'd0;
         reply_id    = 8'd0;
         state_cmd   = 8'd0;
         beats_owed.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            check_beat(rsp_data);
         if (req_valid && req_ready)
            parse_link_item(req_data);
         if (csr_valid && csr_ready)
            state_cmd = csr_data;
      end
      owed_count = beats_owed.size();
   end

endmodule

FILE: verif/packet_request_receiver_core_test.sv
`timescale 1ns / 1ps
// Top-level testbench for the packet request receiver core: stimulus, flow control, verdict.
module packet_request_receiver_core_test;
   import prr_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         IDLE_LIMIT   = 3000;
   localparam int         HOLD_CYCLES  = 400;
   localparam int         DRAIN_CYCLES = 8;
   localparam int         PHASE_ITEMS  = 30;

   logic       clock;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data  = 8'd0;

   int         fail_count;
   int         owed_count;
   int         beats_seen;
   int         exchanges_closed;
   int         acks_seen;
   int         items_sent       = 0;
   int         idle_cycles      = 0;
   int         burst_left       = 0;
   int         settings_written = 0;
   bit         hold_request     = 1'b0;
   logic [7:0] area_cmd         = 8'd0;

   packet_request_receiver_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   packet_request_receiver_checker link_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .owed_count       (owed_count),
      .beats_seen       (beats_seen),
      .exchanges_closed (exchanges_closed),
      .acks_seen        (acks_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("[packet_request_receiver_core] ERROR");
            $finish;
         end
      end
   end

   // Result side: ready pattern changes mode at random intervals; one long hold-off.
   initial begin : receiver
      int mode;
      int span;
      bit held;
      held = 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(8, 48);
         repeat (span) begin
            @(negedge clock);
            if (hold_request && !held) begin
               held      = 1'b1;
               rsp_ready = 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
            end
            case (mode)
               0:       rsp_ready = 1'b1;
               1:       rsp_ready = 1'($urandom_range(0, 1));
               default: rsp_ready = ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   function automatic req_type make_req(input logic [1:0] op, input logic [7:0] cmd,
                                        input logic [7:0] rx);
      req_type r;
      r.op      = op;
      r.command = cmd;
      r.rx_byte = rx;
      return r;
   endfunction

   // Entered and left at a falling edge.
   task automatic offer(input req_type item);
      int gap;
      req_data  = item;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(0, 7);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 24);
      end
   endtask

   task automatic write_area_cmd(input logic [7:0] value);
      req_valid  = 1'b0;
      burst_left = 0;
      wait (owed_count == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      area_cmd  = value;
      settings_written++;
   endtask

   // cut: number of reply bytes after the header to send, negative for all of them.
   task automatic run_exchange(input logic [7:0] cmd, input logic [7:0] hdr,
                               input logic [7:0] id, input int len, input bit corrupt,
                               input int cut, input bit timeout_after);
      logic [7:0] reply[$];
      logic [7:0] sum;
      logic [7:0] b;
      int         i;
      offer(make_req(OP_START, cmd, 8'($urandom_range(0, 255))));
      offer(make_req(OP_BYTE, 8'($urandom_range(0, 255)), hdr));
      if (hdr != REPLY_MARK)
         return;
      reply.push_back(id);
      reply.push_back(8'(len));
      sum = id;
      for (i = 0; i < len; i++) begin
         b = 8'($urandom_range(0, 255));
         reply.push_back(b);
         sum = sum + b;
      end
      if (corrupt)
         sum = sum ^ 8'($urandom_range(1, 255));
      reply.push_back(sum);
      if (cut < 0)
         cut = reply.size();
      for (i = 0; i < cut; i++)
         offer(make_req(OP_BYTE, 8'($urandom_range(0, 255)), reply[i]));
      if (timeout_after)
         offer(make_req(OP_TIMEOUT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
   endtask

   task automatic random_traffic();
      logic [7:0] cmd;
      logic [7:0] hdr;
      logic [7:0] id;
      int         len;
      int         brk;
      int         cut;
      if ($urandom_range(0, 99) < 8) begin
         offer(make_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255))));
      end else begin
         cmd = ($urandom_range(0, 9) < 4) ? area_cmd : 8'($urandom_range(0, 255));
         hdr = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : REPLY_MARK;
         id  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                           : 8'($urandom_range(0, 255));
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
         brk = $urandom_range(0, 9);
         cut = (brk < 2) ? $urandom_range(0, len + 2) : -1;
         run_exchange(cmd, hdr, id, len, ($urandom_range(0, 7) == 0), cut, (brk == 0));
      end
   endtask

   initial begin : stimulus
      int         p;
      int         target;
      logic [7:0] value;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // idle link: timeout, stray byte and the unused op are all dropped
      offer(make_req(OP_TIMEOUT, 8'hFF, 8'hFF));
      offer(make_req(OP_BYTE, 8'h00, REPLY_MARK));
      offer(make_req(OP_UNUSED, 8'hFF, 8'hFF));
      // timeout before any reply reports the link offline
      offer(make_req(OP_START, 8'h00, 8'h00));
      offer(make_req(OP_TIMEOUT, 8'h00, 8'h00));
      run_exchange(8'hFF, 8'h55, 8'h00, 0, 1'b0, -1, 1'b0);
      // state reply longer than the state area
      run_exchange(8'h00, REPLY_MARK, 8'hFF, 7, 1'b0, -1, 1'b0);
      // empty payload carrying a new packet ID
      run_exchange(8'h12, REPLY_MARK, 8'h80, 0, 1'b0, -1, 1'b0);

      for (p = 0; p < 6; p++) begin
         case (p)
            0:       value = 8'hFF;
            1:       value = 8'h00;
            3:       value = 8'h80;
            default: value = 8'($urandom_range(0, 255));
         endcase
         write_area_cmd(value);
         if (p == 0)
            hold_request = 1'b1;
         if (p == 5)
            run_exchange(area_cmd, REPLY_MARK, 8'h7F, 255, 1'b0, -1, 1'b0);
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target)
            random_traffic();
      end

      req_valid = 1'b0;
      wait (owed_count == 0);
      repeat (2 * DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d request items under %0d state command settings; checked %0d beats.",
               items_sent, settings_written, beats_seen);
      $display("Exchanges closed: %0d, acknowledged: %0d, failures: %0d.",
               exchanges_closed, acks_seen, fail_count);
      if (fail_count == 0 && owed_count == 0)
         $display("[packet_request_receiver_core] OK");
      else
         $display("[packet_request_receiver_core] ERROR");
      $finish;
   end

endmodule
